@@ rtl/touch_smoother_with_threshold_defines.svh @@
// Assertion macros for the touch smoother block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef TOUCH_SMOOTHER_WITH_THRESHOLD_DEFINES_SVH
`define TOUCH_SMOOTHER_WITH_THRESHOLD_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TSMTH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TSMTH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tsmth_pkg.sv @@
// Shared types and constants for the touch smoother.
// No dependencies; imported by every module of the block except tsmth_ram.
`timescale 1ns / 1ps

package tsmth_pkg;

  // Window storage depth and derived widths
  localparam int MAX_WINDOW = 16;
  localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // Item fields
  localparam int DATA_W     = 16;
  localparam int SUM_W      = DATA_W + IDX_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  // Configuration registers
  localparam int WIN_CFG_W  = 5;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 4;

  localparam logic [WIN_CFG_W-1:0] POS_WIN_RST = WIN_CFG_W'(10);
  localparam logic [WIN_CFG_W-1:0] DEP_WIN_RST = WIN_CFG_W'(6);
  localparam logic [DATA_W-1:0]    THRESH_RST  = '0;

  typedef enum logic [1:0] {
    REG_POS_WIN = 2'd0,
    REG_DEP_WIN = 2'd1,
    REG_THRESH  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_NEW_TOUCH = 1'b0,
    CMD_SAMPLE    = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  // Sequencer to window control
  typedef struct packed {
    logic clear;
    logic drop;
    logic push;
  } ring_ctl_t;

  // Window control status
  typedef struct packed {
    logic             full;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
  } ring_sts_t;

endpackage

@@ rtl/touch_smoother_with_threshold.sv @@
// Touch smoother top level: sequencer, running sums, config port, output stage.
// Depends on tsmth_pkg, tsmth_ram, tsmth_ring_ctrl, tsmth_serdiv and the defines header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: cmd, touch id,
//   position and depth. Output channel (out_valid_o / out_stall_i) returns one
//   item per input: stored id, averaged x, y, depth and the touching flag.
//   A new-touch item empties both windows and is answered with the raw
//   values. A sample item runs a window read, a window write, a divider load
//   and 20 bit-serial divide steps (three dividers in parallel), one divide
//   step per sum bit, before its result goes to the output register.
//   in_stall_o is low only while the sequencer is idle. The output register
//   holds a result while out_stall_i is high; the next item is still accepted
//   and waits at its final step until the register is free.
//   Registers (APB, 32-bit data): 0x0 position window, 0x4 depth window,
//   0x8 touch threshold. Write them only while the block is idle.
//   Reset empties both windows, clears the stored id and loads the register
//   defaults; window storage is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "touch_smoother_with_threshold_defines.svh"

module touch_smoother_with_threshold (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [tsmth_pkg::DATA_W-1:0]    touch_id_i,
  input  logic [tsmth_pkg::DATA_W-1:0]    pos_x_i,
  input  logic [tsmth_pkg::DATA_W-1:0]    pos_y_i,
  input  logic [tsmth_pkg::DATA_W-1:0]    depth_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tsmth_pkg::DATA_W-1:0]    out_id_o,
  output logic [tsmth_pkg::DATA_W-1:0]    avg_x_o,
  output logic [tsmth_pkg::DATA_W-1:0]    avg_y_o,
  output logic [tsmth_pkg::DATA_W-1:0]    avg_depth_o,
  output logic                            touching_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsmth_pkg::APB_AW-1:0]    paddr,
  input  logic [tsmth_pkg::APB_DW-1:0]    pwdata,
  output logic [tsmth_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);
  import tsmth_pkg::*;

  state_e                state_q, state_d;
  logic                  in_acc;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;

  logic [WIN_CFG_W-1:0]  pos_win_q;
  logic [WIN_CFG_W-1:0]  dep_win_q;
  logic [DATA_W-1:0]     thresh_q;

  logic                  cmd_q;
  logic [DATA_W-1:0]     x_q, y_q, d_q;
  logic [DATA_W-1:0]     cur_id_q;
  logic [SUM_W-1:0]      sum_x_q, sum_y_q, sum_d_q;
  logic [DIV_CNT_W-1:0]  bit_cnt_q;

  ring_ctl_t             pos_ctl, dep_ctl;
  ring_sts_t             pos_sts, dep_sts;
  logic                  ring_we;
  logic [2*DATA_W-1:0]   pos_rdata;
  logic [DATA_W-1:0]     dep_rdata;

  logic                  div_load, div_step;
  logic [DATA_W-1:0]     quot_x, quot_y, quot_d;

  logic                  out_load;
  logic                  out_valid_q;
  logic [DATA_W-1:0]     out_id_q, out_x_q, out_y_q, out_d_q;
  logic                  out_touch_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_win_q <= POS_WIN_RST;
      dep_win_q <= DEP_WIN_RST;
      thresh_q  <= THRESH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_POS_WIN: pos_win_q <= pwdata[WIN_CFG_W-1:0];
        REG_DEP_WIN: dep_win_q <= pwdata[WIN_CFG_W-1:0];
        REG_THRESH:  thresh_q  <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_WIN: prdata = APB_DW'(pos_win_q);
      REG_DEP_WIN: prdata = APB_DW'(dep_win_q);
      REG_THRESH:  prdata = APB_DW'(thresh_q);
      default:     prdata = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pos_ctl  = '0;
    dep_ctl  = '0;
    ring_we  = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_SAMPLE) begin
            state_d = ST_RD;
          end else begin
            pos_ctl.clear = 1'b1;
            dep_ctl.clear = 1'b1;
            state_d       = ST_OUT;
          end
        end
      end
      ST_RD: begin
        // oldest entries are on the RAM outputs now
        pos_ctl.drop = pos_sts.full;
        dep_ctl.drop = dep_sts.full;
        state_d      = ST_WR;
      end
      ST_WR: begin
        pos_ctl.push = 1'b1;
        dep_ctl.push = 1'b1;
        ring_we      = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        div_load = 1'b1;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        div_step = 1'b1;
        if (bit_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Divide step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
    end else if (div_load) begin
      bit_cnt_q <= '0;
    end else if (div_step) begin
      bit_cnt_q <= bit_cnt_q + DIV_CNT_W'(1);
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_i;
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      d_q   <= depth_i;
    end
  end

  // Stored touch id and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_id_q <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_d_q  <= '0;
    end else if (in_acc && cmd_i == CMD_NEW_TOUCH) begin
      cur_id_q <= touch_id_i;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_d_q  <= '0;
    end else if (state_q == ST_RD) begin
      if (pos_sts.full) begin
        sum_x_q <= sum_x_q - SUM_W'(pos_rdata[2*DATA_W-1:DATA_W]);
        sum_y_q <= sum_y_q - SUM_W'(pos_rdata[DATA_W-1:0]);
      end
      if (dep_sts.full) begin
        sum_d_q <= sum_d_q - SUM_W'(dep_rdata);
      end
    end else if (state_q == ST_WR) begin
      sum_x_q <= sum_x_q + SUM_W'(x_q);
      sum_y_q <= sum_y_q + SUM_W'(y_q);
      sum_d_q <= sum_d_q + SUM_W'(d_q);
    end
  end

  // Window pointers
  tsmth_ring_ctrl u_pos_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .win_cfg_i (pos_win_q),
    .ctl_i     (pos_ctl),
    .sts_o     (pos_sts)
  );

  tsmth_ring_ctrl u_dep_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .win_cfg_i (dep_win_q),
    .ctl_i     (dep_ctl),
    .sts_o     (dep_sts)
  );

  // Window storage; x and y share one row
  tsmth_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_WINDOW)
  ) u_pos_mem (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (pos_sts.slot),
    .wdata_i ({x_q, y_q}),
    .raddr_i (pos_sts.head),
    .rdata_o (pos_rdata)
  );

  tsmth_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WINDOW)
  ) u_dep_mem (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (dep_sts.slot),
    .wdata_i (d_q),
    .raddr_i (dep_sts.head),
    .rdata_o (dep_rdata)
  );

  // Three dividers stepped together
  tsmth_serdiv u_div_x (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (sum_x_q),
    .divisor_i  (pos_sts.count),
    .quot_o     (quot_x)
  );

  tsmth_serdiv u_div_y (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (sum_y_q),
    .divisor_i  (pos_sts.count),
    .quot_o     (quot_y)
  );

  tsmth_serdiv u_div_d (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (sum_d_q),
    .divisor_i  (dep_sts.count),
    .quot_o     (quot_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q <= cur_id_q;
      if (cmd_q == CMD_SAMPLE) begin
        out_x_q     <= quot_x;
        out_y_q     <= quot_y;
        out_d_q     <= quot_d;
        out_touch_q <= (quot_d < thresh_q);
      end else begin
        out_x_q     <= x_q;
        out_y_q     <= y_q;
        out_d_q     <= d_q;
        out_touch_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign avg_x_o     = out_x_q;
  assign avg_y_o     = out_y_q;
  assign avg_depth_o = out_d_q;
  assign touching_o  = out_touch_q;

  // Checks
  `TSMTH_ASSERT_IMP(a_pos_cnt_bound, 1'b1, int'(pos_sts.count) <= MAX_WINDOW, "pos count overflow")
  `TSMTH_ASSERT_NXT(a_new_touch_clears, in_acc && cmd_i == CMD_NEW_TOUCH, pos_sts.count == '0 && dep_sts.count == '0 && sum_d_q == '0, "new touch did not empty windows")
  `TSMTH_ASSERT_NXT(a_out_only_from_out, state_q != ST_OUT && !out_valid_q, !out_valid_q, "result raised outside output step")
  `TSMTH_ASSERT_IMP(a_div_nonzero, state_q == ST_LOAD, pos_sts.count != '0 && dep_sts.count != '0, "divide by empty window")

endmodule

@@ rtl/tsmth_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tsmth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port, read port returns old data on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tsmth_ring_ctrl.sv @@
// Fill count and head pointer of one sliding window.
// Depends on tsmth_pkg.
`timescale 1ns / 1ps

module tsmth_ring_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tsmth_pkg::WIN_CFG_W-1:0]     win_cfg_i,
  input  tsmth_pkg::ring_ctl_t                ctl_i,
  output tsmth_pkg::ring_sts_t                sts_o
);
  import tsmth_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] win_len;
  logic [CNT_W:0]   slot_sum;
  logic [CNT_W:0]   slot_wrap;

  // Window length: zero acts as one, oversize acts as the depth
  always_comb begin
    if (win_cfg_i == '0) begin
      win_len = CNT_W'(1);
    end else if (int'(win_cfg_i) > MAX_WINDOW) begin
      win_len = CNT_W'(MAX_WINDOW);
    end else begin
      win_len = CNT_W'(win_cfg_i);
    end
  end

  // Write slot is head plus count, wrapped once
  assign slot_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
  assign slot_wrap = (slot_sum >= (CNT_W + 1)'(MAX_WINDOW)) ?
                     slot_sum - (CNT_W + 1)'(MAX_WINDOW) : slot_sum;

  // Pointer and count updates
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    priority if (ctl_i.clear) begin
      count_d = '0;
      head_d  = '0;
    end else if (ctl_i.drop) begin
      count_d = count_q - CNT_W'(1);
      head_d  = (int'(head_q) == MAX_WINDOW - 1) ? '0 : head_q + IDX_W'(1);
    end else if (ctl_i.push) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  assign sts_o.full  = (count_q >= win_len);
  assign sts_o.head  = head_q;
  assign sts_o.slot  = slot_wrap[IDX_W-1:0];
  assign sts_o.count = count_q;

endmodule

@@ rtl/tsmth_serdiv.sv @@
// Bit-serial restoring divider: one quotient bit per step.
// Depends on tsmth_pkg.
`timescale 1ns / 1ps

module tsmth_serdiv (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic                          step_i,
  input  logic [tsmth_pkg::SUM_W-1:0]   dividend_i,
  input  logic [tsmth_pkg::CNT_W-1:0]   divisor_i,
  output logic [tsmth_pkg::DATA_W-1:0]  quot_o
);
  import tsmth_pkg::*;

  // Dividend shifts out at the top, quotient bits shift in at the bottom
  logic [SUM_W-1:0] dvd_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dvsr_q;
  logic [CNT_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign ge    = (trial >= {1'b0, dvsr_q});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (step_i) begin
      dvd_q <= {dvd_q[SUM_W-2:0], ge};
      rem_q <= ge ? CNT_W'(trial - {1'b0, dvsr_q}) : trial[CNT_W-1:0];
    end
  end

  assign quot_o = dvd_q[DATA_W-1:0];

endmodule
